FILE: rtl/bmpblit_pkg.sv
`default_nettype none

package bmpblit_pkg;

    localparam int MAX_DIM_DEFAULT = 2048;

    localparam int SCREEN_W   = 12;
    localparam int ORIGIN_W   = 11;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int HDR_POS_W  = 6;
    localparam int ADDR_W     = 22;
    localparam int PIXEL_W    = 24;

    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam int FILE_HEADER_BYTES = 14;
    localparam int INFO_HEADER_BYTES = 40;
    localparam int FIELD_BYTES       = 4;
    localparam int WIDTH_POS         = FILE_HEADER_BYTES + 4;
    localparam int HEIGHT_POS        = FILE_HEADER_BYTES + 8;
    localparam int HEADER_LAST       = FILE_HEADER_BYTES + INFO_HEADER_BYTES - 1;

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 12'd800;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH,
        REG_SCREEN_HEIGHT,
        REG_ORIGIN_X,
        REG_ORIGIN_Y
    } reg_index_t;

    typedef enum logic [1:0] {
        PHASE_IDLE,
        PHASE_HEADER,
        PHASE_PIXELS
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_SIGNATURE,
        STATUS_BAD_SIZE
    } status_t;

    typedef struct packed {
        logic [SCREEN_W-1:0] screen_width;
        logic [SCREEN_W-1:0] screen_height;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               on_screen;
        logic               last;
        status_t            status;
    } item_t;

endpackage

`default_nettype wire

FILE: rtl/bmpblit_parse.sv
`default_nettype none

module bmpblit_parse #(
    parameter int MAX_DIM = bmpblit_pkg::MAX_DIM_DEFAULT,
    parameter int DIM_W   = $clog2(MAX_DIM + 1),
    parameter int POS_W   = ((DIM_W > bmpblit_pkg::ORIGIN_W) ? DIM_W
                             : bmpblit_pkg::ORIGIN_W) + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire logic [7:0]        data_byte,
    input  wire logic              first_byte,
    input  wire bmpblit_pkg::cfg_t cfg,
    output logic                   has_result,
    output logic [POS_W-1:0]       col_pos,
    output logic [POS_W-1:0]       row_pos,
    output bmpblit_pkg::item_t     item
);

    localparam int HPW = bmpblit_pkg::HDR_POS_W;

    bmpblit_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [HPW-1:0]   pos_reg, pos_next, pos_cur;
    logic [DIM_W-1:0] img_w_reg, img_w_next, img_w_cur;
    logic [DIM_W-1:0] img_h_reg, img_h_next, img_h_cur;
    logic             w_big_reg, w_big_next, w_big_cur;
    logic             h_big_reg, h_big_next, h_big_cur;
    logic [DIM_W-1:0] col_cnt_reg, col_cnt_next, col_cnt_cur;
    logic [DIM_W-1:0] row_cnt_reg, row_cnt_next, row_cnt_cur;
    logic [1:0]       color_reg, color_next, color_cur;
    logic [1:0]       pad_reg, pad_next, pad_cur;
    logic [15:0]      held_reg, held_next, held_cur;

    logic             in_w_field;
    logic             in_h_field;
    logic [1:0]       field_k;
    logic [31:0]      shifted;
    logic             size_bad;
    logic [DIM_W-1:0] col_inc;
    logic             on_screen;
    logic             final_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= bmpblit_pkg::PHASE_IDLE;
            pos_reg     <= '0;
            img_w_reg   <= '0;
            img_h_reg   <= '0;
            w_big_reg   <= 1'b0;
            h_big_reg   <= 1'b0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            color_reg   <= '0;
            pad_reg     <= '0;
            held_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            img_w_reg   <= img_w_next;
            img_h_reg   <= img_h_next;
            w_big_reg   <= w_big_next;
            h_big_reg   <= h_big_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            color_reg   <= color_next;
            pad_reg     <= pad_next;
            held_reg    <= held_next;
        end
    end

    always_comb
    begin
        // a first byte restarts the parse from a clean header state
        if (first_byte)
        begin
            phase_cur   = bmpblit_pkg::PHASE_HEADER;
            pos_cur     = '0;
            img_w_cur   = '0;
            img_h_cur   = '0;
            w_big_cur   = 1'b0;
            h_big_cur   = 1'b0;
            col_cnt_cur = '0;
            row_cnt_cur = '0;
            color_cur   = '0;
            pad_cur     = '0;
            held_cur    = '0;
        end
        else
        begin
            phase_cur   = phase_reg;
            pos_cur     = pos_reg;
            img_w_cur   = img_w_reg;
            img_h_cur   = img_h_reg;
            w_big_cur   = w_big_reg;
            h_big_cur   = h_big_reg;
            col_cnt_cur = col_cnt_reg;
            row_cnt_cur = row_cnt_reg;
            color_cur   = color_reg;
            pad_cur     = pad_reg;
            held_cur    = held_reg;
        end

        phase_next   = phase_cur;
        pos_next     = pos_cur;
        img_w_next   = img_w_cur;
        img_h_next   = img_h_cur;
        w_big_next   = w_big_cur;
        h_big_next   = h_big_cur;
        col_cnt_next = col_cnt_cur;
        row_cnt_next = row_cnt_cur;
        color_next   = color_cur;
        pad_next     = pad_cur;
        held_next    = held_cur;

        has_result = 1'b0;
        item       = '0;

        in_w_field = (pos_cur >= HPW'(bmpblit_pkg::WIDTH_POS)) &&
                     (pos_cur < HPW'(bmpblit_pkg::WIDTH_POS + bmpblit_pkg::FIELD_BYTES));
        in_h_field = (pos_cur >= HPW'(bmpblit_pkg::HEIGHT_POS)) &&
                     (pos_cur < HPW'(bmpblit_pkg::HEIGHT_POS + bmpblit_pkg::FIELD_BYTES));
        field_k    = in_w_field ? 2'(pos_cur - HPW'(bmpblit_pkg::WIDTH_POS))
                                : 2'(pos_cur - HPW'(bmpblit_pkg::HEIGHT_POS));
        shifted    = 32'(data_byte) << {field_k, 3'b000};

        col_pos = POS_W'(cfg.origin_x) + POS_W'(col_cnt_cur);
        row_pos = POS_W'(cfg.origin_y) + POS_W'(img_h_cur) - POS_W'(1)
                  - POS_W'(row_cnt_cur);
        on_screen   = (col_pos < POS_W'(cfg.screen_width)) &&
                      (row_pos < POS_W'(cfg.screen_height));
        final_pixel = (row_cnt_cur == img_h_cur - DIM_W'(1)) &&
                      (col_cnt_cur == img_w_cur - DIM_W'(1));
        col_inc     = col_cnt_cur + DIM_W'(1);

        if (in_w_field)
        begin
            img_w_next = img_w_cur | shifted[DIM_W-1:0];
            w_big_next = w_big_cur | (|shifted[31:DIM_W]);
        end
        if (in_h_field)
        begin
            img_h_next = img_h_cur | shifted[DIM_W-1:0];
            h_big_next = h_big_cur | (|shifted[31:DIM_W]);
        end
        size_bad = w_big_next || (img_w_next == '0) || (img_w_next > DIM_W'(MAX_DIM)) ||
                   h_big_next || (img_h_next == '0) || (img_h_next > DIM_W'(MAX_DIM));

        unique case (phase_cur)
            bmpblit_pkg::PHASE_HEADER:
            begin
                if (pos_cur == '0)
                begin
                    held_next = 16'(data_byte);
                end
                if ((pos_cur == HPW'(1)) &&
                    ({data_byte, held_cur[7:0]} != bmpblit_pkg::BMP_SIGNATURE))
                begin
                    has_result  = 1'b1;
                    item.last   = 1'b1;
                    item.status = bmpblit_pkg::STATUS_BAD_SIGNATURE;
                    phase_next  = bmpblit_pkg::PHASE_IDLE;
                end
                else if ((pos_cur == HPW'(bmpblit_pkg::HEIGHT_POS +
                                          bmpblit_pkg::FIELD_BYTES - 1)) && size_bad)
                begin
                    has_result  = 1'b1;
                    item.last   = 1'b1;
                    item.status = bmpblit_pkg::STATUS_BAD_SIZE;
                    phase_next  = bmpblit_pkg::PHASE_IDLE;
                end
                else if (pos_cur == HPW'(bmpblit_pkg::HEADER_LAST))
                begin
                    phase_next   = bmpblit_pkg::PHASE_PIXELS;
                    col_cnt_next = '0;
                    row_cnt_next = '0;
                    color_next   = '0;
                    pad_next     = '0;
                    held_next    = '0;
                end
                else
                begin
                    pos_next = pos_cur + HPW'(1);
                end
            end
            bmpblit_pkg::PHASE_PIXELS:
            begin
                if (pad_cur != '0)
                begin
                    pad_next = pad_cur - 2'd1;
                end
                else if (color_cur == 2'd1)
                begin
                    held_next  = {data_byte, held_cur[7:0]};
                    color_next = 2'd2;
                end
                else if (color_cur != 2'd2)
                begin
                    held_next  = 16'(data_byte);
                    color_next = 2'd1;
                end
                else
                begin
                    color_next = 2'd0;
                    if (final_pixel)
                    begin
                        phase_next = bmpblit_pkg::PHASE_IDLE;
                    end
                    else if (col_inc >= img_w_cur)
                    begin
                        col_cnt_next = '0;
                        row_cnt_next = row_cnt_cur + DIM_W'(1);
                        pad_next     = img_w_cur[1:0];
                    end
                    else
                    begin
                        col_cnt_next = col_inc;
                    end
                    has_result     = on_screen || final_pixel;
                    item.pixel     = {data_byte, held_cur};
                    item.on_screen = on_screen;
                    item.last      = final_pixel;
                    item.status    = bmpblit_pkg::STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bmp24_stream_to_framebuffer_blit.sv
// 24-bit bitmap byte stream to framebuffer write stream
// byte channel: data_byte/first_byte with byte_valid, byte_stall; one byte per
// cycle while byte_stall is low, first_byte restarts the parse at any point
// pixel channel: fb_address, pixel_value, write_enable, status, last with
// pixel_valid, pixel_stall; one transfer per on-screen pixel, one for the
// final pixel (last set) and one for a bad signature or size (last set)
// cfg channel: cfg_valid/cfg_ready with cfg_index, cfg_data; always ready,
// write only while no file is in flight
// throughput: one byte per cycle while byte_stall is low, set by the parse state
// update which finishes within the cycle of the byte transfer
// pipeline: from byte transfer to pixel_valid the parse stage feeds a holding
// register, then the address multiply feeds the output register
// reset clears the parse to idle, empties both registers and loads the
// default screen size 800 x 480 at origin 0, 0
// while pixel_stall is high the output holds; the holding register still
// takes one more result, after which byte_stall rises until room frees up
`default_nettype none

module bmp24_stream_to_framebuffer_blit #(
    parameter int MAX_DIM = bmpblit_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  byte_valid,
    output logic                                       byte_stall,
    input  wire logic [7:0]                            data_byte,
    input  wire logic                                  first_byte,
    output logic                                       pixel_valid,
    input  wire logic                                  pixel_stall,
    output logic [bmpblit_pkg::ADDR_W-1:0]             fb_address,
    output logic [bmpblit_pkg::PIXEL_W-1:0]            pixel_value,
    output logic                                       write_enable,
    output logic [1:0]                                 status,
    output logic                                       last,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bmpblit_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bmpblit_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int POS_W = ((DIM_W > bmpblit_pkg::ORIGIN_W) ? DIM_W
                            : bmpblit_pkg::ORIGIN_W) + 1;
    localparam int SW    = bmpblit_pkg::SCREEN_W;
    localparam int AW    = bmpblit_pkg::ADDR_W;

    bmpblit_pkg::cfg_t  cfg_reg;
    logic               take;
    logic               has_result;
    logic [POS_W-1:0]   col_pos;
    logic [POS_W-1:0]   row_pos;
    bmpblit_pkg::item_t item;

    logic               s1_valid_reg, s1_valid_next;
    logic [POS_W-1:0]   s1_col_reg;
    logic [POS_W-1:0]   s1_row_reg;
    bmpblit_pkg::item_t s1_item_reg;
    logic               s2_load;

    logic                   out_valid_reg, out_valid_next;
    logic [AW-1:0]          fb_address_reg, fb_address_next;
    logic [2*SW-1:0]        product;
    bmpblit_pkg::item_t     out_item_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= bmpblit_pkg::SCREEN_WIDTH_RESET;
            cfg_reg.screen_height <= bmpblit_pkg::SCREEN_HEIGHT_RESET;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bmpblit_pkg::reg_index_t'(cfg_index))
                bmpblit_pkg::REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SW-1:0];
                bmpblit_pkg::REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SW-1:0];
                bmpblit_pkg::REG_ORIGIN_X:
                    cfg_reg.origin_x <= cfg_data[bmpblit_pkg::ORIGIN_W-1:0];
                bmpblit_pkg::REG_ORIGIN_Y:
                    cfg_reg.origin_y <= cfg_data[bmpblit_pkg::ORIGIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign s2_load    = s1_valid_reg && (!out_valid_reg || !pixel_stall);
    assign byte_stall = s1_valid_reg && !s2_load;
    assign take       = byte_valid && !byte_stall;

    bmpblit_parse #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W),
        .POS_W   (POS_W)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .cfg        (cfg_reg),
        .has_result (has_result),
        .col_pos    (col_pos),
        .row_pos    (row_pos),
        .item       (item)
    );

    // holding register between parse and address stage
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take && has_result)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && has_result)
        begin
            s1_col_reg  <= col_pos;
            s1_row_reg  <= row_pos;
            s1_item_reg <= item;
        end
    end

    // on screen both coordinates fit in SW bits, the width of the screen size fields
    assign product = s1_row_reg[SW-1:0] * cfg_reg.screen_width;

    always_comb
    begin
        if (s1_item_reg.on_screen)
        begin
            fb_address_next = AW'(product + (2*SW)'(s1_col_reg[SW-1:0]));
        end
        else
        begin
            fb_address_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s2_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pixel_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            fb_address_reg <= fb_address_next;
            out_item_reg   <= s1_item_reg;
        end
    end

    assign pixel_valid  = out_valid_reg;
    assign fb_address   = fb_address_reg;
    assign pixel_value  = out_item_reg.pixel;
    assign write_enable = out_item_reg.on_screen;
    assign status       = out_item_reg.status;
    assign last         = out_item_reg.last;

endmodule

`default_nettype wire

FILE: rtl/bmpblit_checker.sv
`default_nettype none

module bmpblit_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                byte_valid,
    input wire logic                                byte_stall,
    input wire logic                                pixel_valid,
    input wire logic                                pixel_stall,
    input wire logic [bmpblit_pkg::ADDR_W-1:0]      fb_address,
    input wire logic [bmpblit_pkg::PIXEL_W-1:0]     pixel_value,
    input wire logic                                write_enable,
    input wire logic [1:0]                          status,
    input wire logic                                last
);

    // nothing leaves the block in the cycle after reset
    assert property (@(posedge clk) !rst_n |=> !pixel_valid)
        else $error("pixel transfer right after reset");

    // a stalled transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(fb_address) &&
            $stable(pixel_value) && $stable(write_enable) && $stable(status) &&
            $stable(last))
        else $error("stalled pixel transfer changed");

    // an error ends the file and carries no pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && (status != bmpblit_pkg::STATUS_OK) |->
            last && !write_enable && (fb_address == '0) && (pixel_value == '0))
        else $error("malformed error transfer");

    // a clipped pixel only appears as the final one, at address zero
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !write_enable |-> last && (fb_address == '0))
        else $error("clipped pixel transfer that is not final");

    // a stalled byte channel means the pipeline is full
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |-> pixel_valid && pixel_stall)
        else $error("byte stall without a stalled pixel transfer");

endmodule

bind bmp24_stream_to_framebuffer_blit bmpblit_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .fb_address   (fb_address),
    .pixel_value  (pixel_value),
    .write_enable (write_enable),
    .status       (status),
    .last         (last)
);

`default_nettype wire
